// ===== rtl/ntc_pkg.sv =====
// package with state codes, character classes and transition tables of the token checker
`timescale 1ns / 1ps

package ntc_pkg;

    localparam int CHAR_W = 8;
    localparam int NUM_W  = 4;
    localparam int NAME_W = 3;
    localparam int VERD_W = 3;

    typedef logic [NUM_W-1:0]  num_state_t;
    typedef logic [NAME_W-1:0] name_state_t;
    typedef logic [VERD_W-1:0] num_verdict_t;

    localparam num_state_t NS_START    = 4'd0;
    localparam num_state_t NS_SIGN     = 4'd1;
    localparam num_state_t NS_DOT      = 4'd2;
    localparam num_state_t NS_S3       = 4'd3;
    localparam num_state_t NS_S4       = 4'd4;
    localparam num_state_t NS_EXP      = 4'd5;
    localparam num_state_t NS_EXP_DIG  = 4'd6;
    localparam num_state_t NS_TRAIL    = 4'd7;
    localparam num_state_t NS_INT      = 4'd8;
    localparam num_state_t NS_FRAC     = 4'd9;
    localparam num_state_t NS_EXP_SIGN = 4'd10;
    localparam num_state_t NS_DEAD     = 4'd11;

    localparam name_state_t IS_START  = 3'd0;
    localparam name_state_t IS_LETTER = 3'd1;
    localparam name_state_t IS_DIGIT  = 3'd2;
    localparam name_state_t IS_TRAIL  = 3'd3;
    localparam name_state_t IS_DEAD   = 3'd4;

    localparam num_verdict_t NV_INVALID = 3'd0;
    localparam num_verdict_t NV_DECIMAL = 3'd1;
    localparam num_verdict_t NV_INTEGER = 3'd2;
    localparam num_verdict_t NV_SCI     = 3'd3;
    localparam num_verdict_t NV_TRAIL   = 3'd4;

    typedef enum logic [2:0] {
        NC_BLANK,
        NC_SIGN,
        NC_DOT,
        NC_EXPMARK,
        NC_DIGIT,
        NC_OTHER
    } num_class_t;

    typedef enum logic [1:0] {
        IC_BLANK,
        IC_LETTER,
        IC_DIGIT,
        IC_OTHER
    } name_class_t;

    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BLANK  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2e;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_E   = 8'h45;
    localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5a;
    localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5f;
    localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_E   = 8'h65;
    localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7a;

    typedef struct packed {
        num_state_t   num_next;
        name_state_t  name_next;
        num_verdict_t num_verdict;
        logic         name_verdict;
    } step_t;

    function automatic num_class_t num_class(input logic [CHAR_W-1:0] c);
        num_class_t r;
        if (c >= CH_ZERO && c <= CH_NINE) r = NC_DIGIT;
        else if (c == CH_PLUS || c == CH_MINUS) r = NC_SIGN;
        else if (c == CH_BLANK) r = NC_BLANK;
        else if (c == CH_DOT) r = NC_DOT;
        else if (c == CH_LO_E || c == CH_UP_E) r = NC_EXPMARK;
        else r = NC_OTHER;
        return r;
    endfunction

    function automatic name_class_t name_class(input logic [CHAR_W-1:0] c);
        name_class_t r;
        if (c >= CH_ZERO && c <= CH_NINE) r = IC_DIGIT;
        else if ((c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z)
                 || c == CH_UNDER) r = IC_LETTER;
        else if (c == CH_BLANK) r = IC_BLANK;
        else r = IC_OTHER;
        return r;
    endfunction

    function automatic num_state_t num_next(input num_state_t s, input num_class_t k);
        num_state_t r;
        r = NS_DEAD;
        unique case (s) inside
            NS_START: begin
                case (k)
                    NC_BLANK: r = NS_START;
                    NC_SIGN:  r = NS_SIGN;
                    NC_DOT:   r = NS_DOT;
                    NC_DIGIT: r = NS_INT;
                    default:  r = NS_DEAD;
                endcase
            end
            NS_SIGN: begin
                case (k)
                    NC_DOT:   r = NS_DOT;
                    NC_DIGIT: r = NS_INT;
                    default:  r = NS_DEAD;
                endcase
            end
            NS_DOT: begin
                r = (k == NC_DIGIT) ? NS_FRAC : NS_DEAD;
            end
            NS_S3: begin
                case (k)
                    NC_DOT:     r = NS_S4;
                    NC_EXPMARK: r = NS_EXP;
                    NC_DIGIT:   r = NS_S3;
                    default:    r = NS_DEAD;
                endcase
            end
            NS_S4, NS_FRAC: begin
                case (k)
                    NC_BLANK:   r = NS_TRAIL;
                    NC_EXPMARK: r = NS_EXP;
                    NC_DIGIT:   r = NS_FRAC;
                    default:    r = NS_DEAD;
                endcase
            end
            NS_EXP: begin
                case (k)
                    NC_SIGN:  r = NS_EXP_SIGN;
                    NC_DIGIT: r = NS_EXP_DIG;
                    default:  r = NS_DEAD;
                endcase
            end
            NS_EXP_DIG: begin
                case (k)
                    NC_BLANK: r = NS_TRAIL;
                    NC_DIGIT: r = NS_EXP_DIG;
                    default:  r = NS_DEAD;
                endcase
            end
            NS_TRAIL: begin
                r = (k == NC_BLANK) ? NS_TRAIL : NS_DEAD;
            end
            NS_INT: begin
                case (k)
                    NC_BLANK:   r = NS_TRAIL;
                    NC_DOT:     r = NS_FRAC;
                    NC_EXPMARK: r = NS_EXP;
                    NC_DIGIT:   r = NS_INT;
                    default:    r = NS_DEAD;
                endcase
            end
            NS_EXP_SIGN: begin
                r = (k == NC_DIGIT) ? NS_EXP_DIG : NS_DEAD;
            end
            default: r = NS_DEAD;
        endcase
        return r;
    endfunction

    function automatic num_verdict_t num_end(input num_state_t s);
        num_verdict_t r;
        unique case (s) inside
            NS_S3, NS_EXP_DIG: r = NV_SCI;
            NS_S4, NS_FRAC:    r = NV_DECIMAL;
            NS_TRAIL:          r = NV_TRAIL;
            NS_INT:            r = NV_INTEGER;
            default:           r = NV_INVALID;
        endcase
        return r;
    endfunction

    function automatic name_state_t name_next(input name_state_t s, input name_class_t k);
        name_state_t r;
        unique case (s) inside
            IS_START: begin
                case (k)
                    IC_BLANK:  r = IS_START;
                    IC_LETTER: r = IS_LETTER;
                    default:   r = IS_DEAD;
                endcase
            end
            IS_LETTER, IS_DIGIT: begin
                case (k)
                    IC_BLANK:  r = IS_TRAIL;
                    IC_LETTER: r = IS_LETTER;
                    IC_DIGIT:  r = IS_DIGIT;
                    default:   r = IS_DEAD;
                endcase
            end
            IS_TRAIL: begin
                r = (k == IC_BLANK) ? IS_TRAIL : IS_DEAD;
            end
            default: r = IS_DEAD;
        endcase
        return r;
    endfunction

    function automatic logic name_end(input name_state_t s);
        return (s == IS_LETTER) || (s == IS_DIGIT) || (s == IS_TRAIL);
    endfunction

endpackage

// ===== rtl/ntc_dfa.sv =====
// one step of both recognizers: next states and end-of-token verdicts
`timescale 1ns / 1ps

module ntc_dfa (
    input  ntc_pkg::num_state_t        num_state,
    input  ntc_pkg::name_state_t       name_state,
    input  logic [ntc_pkg::CHAR_W-1:0] char_in,
    output ntc_pkg::step_t             step
);

    always_comb begin
        step.num_next     = ntc_pkg::num_next(num_state, ntc_pkg::num_class(char_in));
        step.name_next    = ntc_pkg::name_next(name_state, ntc_pkg::name_class(char_in));
        step.num_verdict  = ntc_pkg::num_end(num_state);
        step.name_verdict = ntc_pkg::name_end(name_state);
    end

endmodule

// ===== rtl/number_and_identifier_token_checker.sv =====
// top level of the number and identifier token checker
//
//   channel | dir | tdata                                   | tlast
//   s_      | in  | [7:0] character                         | end_of_token
//   m_      | out | [2:0] number_verdict, [3] name_verdict  | -
//
// one character beat per cycle while s_tready is high; results are registered
// the recognizer states update at the input beat itself, so beats run back to back
// an output register plus one skid entry hold results while m_tready is low
// s_tready drops only while the skid entry is full
// synchronous active-low reset returns both recognizers to their start state
`timescale 1ns / 1ps

module number_and_identifier_token_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] character
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [2:0] number_verdict, [3] name_verdict
);

    ntc_pkg::num_state_t  num_state_reg, num_state_next;
    ntc_pkg::name_state_t name_state_reg, name_state_next;
    ntc_pkg::step_t       step;

    logic [3:0] out_reg, out_next;
    logic [3:0] skid_reg, skid_next;
    logic       out_valid_reg, out_valid_next;
    logic       skid_valid_reg, skid_valid_next;
    logic       in_beat, token_end, res_beat;
    logic [3:0] result;

    ntc_dfa u_dfa (
        .num_state  (num_state_reg),
        .name_state (name_state_reg),
        .char_in    (s_tdata),
        .step       (step)
    );

    assign s_tready  = !skid_valid_reg;
    assign in_beat   = s_tvalid && s_tready;
    assign token_end = s_tlast || (s_tdata == ntc_pkg::CH_NUL);
    assign res_beat  = in_beat && token_end;
    assign result    = {step.name_verdict, step.num_verdict};

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg};

    always_comb begin
        num_state_next  = num_state_reg;
        name_state_next = name_state_reg;
        if (in_beat) begin
            if (token_end) begin
                num_state_next  = ntc_pkg::NS_START;
                name_state_next = ntc_pkg::IS_START;
            end else begin
                num_state_next  = step.num_next;
                name_state_next = step.name_next;
            end
        end
    end

    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = result;
                out_valid_next = res_beat;
            end
        end else if (res_beat) begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_state_reg  <= ntc_pkg::NS_START;
            name_state_reg <= ntc_pkg::IS_START;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            num_state_reg  <= num_state_next;
            name_state_reg <= name_state_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

// ===== rtl/ntc_checker.sv =====
// port-level checker for the token checker and its bind
`timescale 1ns / 1ps

module ntc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // stalled result beat stays put
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // number verdict in range and padding bits zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= 3'd4 && m_tdata[7:4] == 4'd0)
        else $error("bad result encoding");

    // a token cannot be both a number and an identifier
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tdata[2:0] == 3'd0)
        else $error("token reported as number and identifier");

    // a character that does not end a token makes no result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tlast && s_tdata != 8'h00 && !m_tvalid |=> !m_tvalid)
        else $error("result without token end");

    // input stalls only while a result is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

endmodule

bind number_and_identifier_token_checker ntc_checker u_ntc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/number_and_identifier_token_checker_test.sv =====
// self-checking testbench of the number and identifier token checker
`timescale 1ns / 1ps

module number_and_identifier_token_checker_test;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_BEATS   = 1950;

    typedef struct packed {
        logic                  name;
        ntc_pkg::num_verdict_t num;
    } verdict_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HALF,
        RX_HEAVY
    } rx_mode_t;

    localparam ntc_pkg::num_state_t NUM_STEP [12][6] = '{
        '{ntc_pkg::NS_START, ntc_pkg::NS_SIGN, ntc_pkg::NS_DOT, ntc_pkg::NS_DEAD,
          ntc_pkg::NS_INT, ntc_pkg::NS_DEAD},
        '{ntc_pkg::NS_DEAD, ntc_pkg::NS_DEAD, ntc_pkg::NS_DOT, ntc_pkg::NS_DEAD,
          ntc_pkg::NS_INT, ntc_pkg::NS_DEAD},
        '{ntc_pkg::NS_DEAD, ntc_pkg::NS_DEAD, ntc_pkg::NS_DEAD, ntc_pkg::NS_DEAD,
          ntc_pkg::NS_FRAC, ntc_pkg::NS_DEAD},
        '{ntc_pkg::NS_DEAD, ntc_pkg::NS_DEAD, ntc_pkg::NS_S4, ntc_pkg::NS_EXP,
          ntc_pkg::NS_S3, ntc_pkg::NS_DEAD},
        '{ntc_pkg::NS_TRAIL, ntc_pkg::NS_DEAD, ntc_pkg::NS_DEAD, ntc_pkg::NS_EXP,
          ntc_pkg::NS_FRAC, ntc_pkg::NS_DEAD},
        '{ntc_pkg::NS_DEAD, ntc_pkg::NS_EXP_SIGN, ntc_pkg::NS_DEAD, ntc_pkg::NS_DEAD,
          ntc_pkg::NS_EXP_DIG, ntc_pkg::NS_DEAD},
        '{ntc_pkg::NS_TRAIL, ntc_pkg::NS_DEAD, ntc_pkg::NS_DEAD, ntc_pkg::NS_DEAD,
          ntc_pkg::NS_EXP_DIG, ntc_pkg::NS_DEAD},
        '{ntc_pkg::NS_TRAIL, ntc_pkg::NS_DEAD, ntc_pkg::NS_DEAD, ntc_pkg::NS_DEAD,
          ntc_pkg::NS_DEAD, ntc_pkg::NS_DEAD},
        '{ntc_pkg::NS_TRAIL, ntc_pkg::NS_DEAD, ntc_pkg::NS_FRAC, ntc_pkg::NS_EXP,
          ntc_pkg::NS_INT, ntc_pkg::NS_DEAD},
        '{ntc_pkg::NS_TRAIL, ntc_pkg::NS_DEAD, ntc_pkg::NS_DEAD, ntc_pkg::NS_EXP,
          ntc_pkg::NS_FRAC, ntc_pkg::NS_DEAD},
        '{ntc_pkg::NS_DEAD, ntc_pkg::NS_DEAD, ntc_pkg::NS_DEAD, ntc_pkg::NS_DEAD,
          ntc_pkg::NS_EXP_DIG, ntc_pkg::NS_DEAD},
        '{ntc_pkg::NS_DEAD, ntc_pkg::NS_DEAD, ntc_pkg::NS_DEAD, ntc_pkg::NS_DEAD,
          ntc_pkg::NS_DEAD, ntc_pkg::NS_DEAD}
    };

    localparam ntc_pkg::num_verdict_t NUM_VERDICT [12] = '{
        ntc_pkg::NV_INVALID, ntc_pkg::NV_INVALID, ntc_pkg::NV_INVALID, ntc_pkg::NV_SCI,
        ntc_pkg::NV_DECIMAL, ntc_pkg::NV_INVALID, ntc_pkg::NV_SCI, ntc_pkg::NV_TRAIL,
        ntc_pkg::NV_INTEGER, ntc_pkg::NV_DECIMAL, ntc_pkg::NV_INVALID, ntc_pkg::NV_INVALID
    };

    localparam ntc_pkg::name_state_t NAME_STEP [5][4] = '{
        '{ntc_pkg::IS_START, ntc_pkg::IS_LETTER, ntc_pkg::IS_DEAD, ntc_pkg::IS_DEAD},
        '{ntc_pkg::IS_TRAIL, ntc_pkg::IS_LETTER, ntc_pkg::IS_DIGIT, ntc_pkg::IS_DEAD},
        '{ntc_pkg::IS_TRAIL, ntc_pkg::IS_LETTER, ntc_pkg::IS_DIGIT, ntc_pkg::IS_DEAD},
        '{ntc_pkg::IS_TRAIL, ntc_pkg::IS_DEAD, ntc_pkg::IS_DEAD, ntc_pkg::IS_DEAD},
        '{ntc_pkg::IS_DEAD, ntc_pkg::IS_DEAD, ntc_pkg::IS_DEAD, ntc_pkg::IS_DEAD}
    };

    localparam logic NAME_VERDICT [5] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    ntc_pkg::num_state_t  num_track;
    ntc_pkg::name_state_t name_track;
    verdict_t             verdict_q[$];
    logic [7:0]           token_chars[$];
    int                   mismatches = 0;
    int                   beats_sent;
    int                   burst_left;
    int                   quiet_cycles = 0;
    int                   rx_left = 0;
    rx_mode_t             rx_mode = RX_OPEN;

    number_and_identifier_token_checker u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic ntc_pkg::num_class_t num_kind(input logic [7:0] c);
        if (c == ntc_pkg::CH_BLANK) return ntc_pkg::NC_BLANK;
        if (c == ntc_pkg::CH_DOT) return ntc_pkg::NC_DOT;
        if (c == ntc_pkg::CH_PLUS || c == ntc_pkg::CH_MINUS) return ntc_pkg::NC_SIGN;
        if (c == ntc_pkg::CH_LO_E || c == ntc_pkg::CH_UP_E) return ntc_pkg::NC_EXPMARK;
        if (c >= ntc_pkg::CH_ZERO && c <= ntc_pkg::CH_NINE) return ntc_pkg::NC_DIGIT;
        return ntc_pkg::NC_OTHER;
    endfunction

    function automatic ntc_pkg::name_class_t name_kind(input logic [7:0] c);
        if (c == ntc_pkg::CH_BLANK) return ntc_pkg::IC_BLANK;
        if (c >= ntc_pkg::CH_ZERO && c <= ntc_pkg::CH_NINE) return ntc_pkg::IC_DIGIT;
        if (c == ntc_pkg::CH_UNDER || (c >= ntc_pkg::CH_UP_A && c <= ntc_pkg::CH_UP_Z)
            || (c >= ntc_pkg::CH_LO_A && c <= ntc_pkg::CH_LO_Z))
            return ntc_pkg::IC_LETTER;
        return ntc_pkg::IC_OTHER;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatches++;
    endtask

    // advance both recognizers by one accepted beat
    task automatic track_beat(input logic [7:0] ch, input logic last);
        verdict_t v;
        if (last || ch == ntc_pkg::CH_NUL) begin
            v.num  = NUM_VERDICT[num_track];
            v.name = NAME_VERDICT[name_track];
            verdict_q.push_back(v);
            num_track  = ntc_pkg::NS_START;
            name_track = ntc_pkg::IS_START;
        end else begin
            num_track  = NUM_STEP[num_track][num_kind(ch)];
            name_track = NAME_STEP[name_track][name_kind(ch)];
        end
    endtask

    task automatic send_beat(input logic [7:0] ch, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        track_beat(ch, last);
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string txt, input logic [7:0] end_ch, input logic end_last);
        for (int i = 0; i < txt.len(); i++)
            send_beat(txt[i], 1'b0);
        send_beat(end_ch, end_last);
    endtask

    task automatic send_token();
        foreach (token_chars[i])
            send_beat(token_chars[i], 1'b0);
        if ($urandom_range(0, 3) == 0)
            send_beat(ntc_pkg::CH_NUL, 1'b0);
        else
            send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(negedge aclk);
        while (verdict_q.size() != 0) @(negedge aclk);
    endtask

    task automatic push_blanks(input int most);
        repeat ($urandom_range(0, most)) token_chars.push_back(ntc_pkg::CH_BLANK);
    endtask

    task automatic push_digits(input int fewest, input int most);
        repeat ($urandom_range(fewest, most))
            token_chars.push_back(8'(ntc_pkg::CH_ZERO + $urandom_range(0, 9)));
    endtask

    function automatic logic [7:0] word_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26) return 8'(ntc_pkg::CH_LO_A + r);
        if (r < 52) return 8'(ntc_pkg::CH_UP_A + (r - 26));
        if (r < 62) return 8'(ntc_pkg::CH_ZERO + (r - 52));
        return ntc_pkg::CH_UNDER;
    endfunction

    task automatic gen_number();
        int form;
        form = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) push_blanks(2);
        if ($urandom_range(0, 1))
            token_chars.push_back($urandom_range(0, 1) ? ntc_pkg::CH_PLUS : ntc_pkg::CH_MINUS);
        if (form != 2) push_digits(1, 4);
        if (form != 0) token_chars.push_back(ntc_pkg::CH_DOT);
        if (form == 1 || form == 2) push_digits(1, 3);
        if ($urandom_range(0, 9) < 3) begin
            token_chars.push_back($urandom_range(0, 1) ? ntc_pkg::CH_LO_E : ntc_pkg::CH_UP_E);
            if ($urandom_range(0, 1))
                token_chars.push_back($urandom_range(0, 1) ? ntc_pkg::CH_PLUS
                                                           : ntc_pkg::CH_MINUS);
            push_digits(1, 3);
        end
        if ($urandom_range(0, 3) == 0) push_blanks(2);
    endtask

    task automatic gen_name();
        if ($urandom_range(0, 3) == 0) push_blanks(2);
        token_chars.push_back($urandom_range(0, 9) == 0 ? ntc_pkg::CH_UNDER
                                                        : word_char() | 8'h40);
        repeat ($urandom_range(0, 6)) token_chars.push_back(word_char());
        if ($urandom_range(0, 3) == 0) push_blanks(2);
    endtask

    task automatic test_number_tokens();
        send_text("-1.5e+3", ntc_pkg::CH_LO_E, 1'b1);
        send_text("12 ", ntc_pkg::CH_NUL, 1'b0);
        send_text("", 8'hff, 1'b1);
        send_text("1e.5", ntc_pkg::CH_NUL, 1'b0);
        send_text("3.", ntc_pkg::CH_BLANK, 1'b1);
        send_text("+.5", ntc_pkg::CH_NUL, 1'b0);
        send_text("7E-0 ", ntc_pkg::CH_ZERO, 1'b1);
        send_text("   ", ntc_pkg::CH_NUL, 1'b0);
        send_text("8", ntc_pkg::CH_NUL, 1'b0);
    endtask

    task automatic test_name_tokens();
        send_text(" _a9 ", ntc_pkg::CH_NUL, 1'b0);
        send_text("Zz", ntc_pkg::CH_UNDER, 1'b1);
        send_text("a b", ntc_pkg::CH_NUL, 1'b0);
        send_text("9a", ntc_pkg::CH_NUL, 1'b0);
        send_text("\377", ntc_pkg::CH_UP_A, 1'b1);
        send_text("x\200", ntc_pkg::CH_NUL, 1'b0);
    endtask

    task automatic test_random_tokens(input int beat_goal);
        int pick;
        while (beats_sent < beat_goal) begin
            token_chars.delete();
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                gen_number();
            end else if (pick < 70) begin
                gen_name();
            end else if (pick < 85) begin
                if ($urandom_range(0, 1)) gen_number(); else gen_name();
                token_chars[$urandom_range(0, token_chars.size() - 1)] =
                    8'($urandom_range(0, 255));
            end else begin
                repeat ($urandom_range(0, 5))
                    token_chars.push_back(8'($urandom_range(1, 255)));
            end
            send_token();
        end
    endtask

    task automatic test_drain_pause();
        drain();
        send_text("6.02e23", ntc_pkg::CH_NUL, 1'b0);
    endtask

    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(32, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:  m_tready <= 1'b1;
            RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
            RX_HALF:  m_tready <= ($urandom_range(0, 1) != 0);
            default:  m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("result beat 0x%02h with no token ended", m_tdata));
            end else begin
                want = verdict_q.pop_front();
                if (m_tdata[2:0] !== want.num)
                    report_mismatch($sformatf("number_verdict %0d, expected %0d",
                                              m_tdata[2:0], want.num));
                if (m_tdata[3] !== want.name)
                    report_mismatch($sformatf("name_verdict %0b, expected %0b",
                                              m_tdata[3], want.name));
                if (m_tdata[7:4] !== 4'd0)
                    report_mismatch($sformatf("tdata pad bits 0x%01h", m_tdata[7:4]));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = ntc_pkg::CH_NUL;
        s_tlast      = 1'b0;
        beats_sent   = 0;
        burst_left   = 0;
        num_track    = ntc_pkg::NS_START;
        name_track   = ntc_pkg::IS_START;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        test_number_tokens();
        test_name_tokens();
        test_random_tokens(RANDOM_BEATS / 2);
        test_drain_pause();
        test_random_tokens(RANDOM_BEATS);
        drain();
        repeat (8) @(posedge aclk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
